FILE: hw/rtl/itm_trace_packet_decoder_defines.svh
// ---------------------------------------------------------------------------
// ITM trace packet decoder: assertion macros
// Shared assertion wrappers; defining NO_ASSERTIONS removes every check.
// ---------------------------------------------------------------------------
`ifndef ITM_TRACE_PACKET_DECODER_DEFINES_SVH
`define ITM_TRACE_PACKET_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define ITMD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("itmd: assertion failed");
// Condition in one cycle must be followed by a consequence in the next.
`define ITMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itmd: sequence check failed");
`else
`define ITMD_ASSERT(lbl, clk, rst_n, prop)
`define ITMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/itmd_pkg.sv
// ---------------------------------------------------------------------------
// ITM trace packet decoder package
// Parser modes, header constants and the result record.
// ---------------------------------------------------------------------------
`default_nettype none

package itmd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SYNC = 2'd1,
        MODE_TS   = 2'd2,
        MODE_SWIT = 2'd3
    } mode_t;

    localparam logic [7:0] OVERFLOW_HDR       = 8'h70;
    localparam logic [7:0] HDR_TYPE_MASK      = 8'h0F;
    localparam logic [7:0] HDR_RESERVED       = 8'h04;
    localparam logic [7:0] HDR_HW_BIT         = 8'h04;
    localparam logic [7:0] HDR_PORT_MASK      = 8'hF8;
    localparam logic [7:0] HDR_SIZE_MASK      = 8'h03;
    localparam logic [7:0] CONT_BIT           = 8'h80;
    localparam logic [1:0] SIZE_WORD          = 2'd3;
    localparam logic [2:0] SYNC_LIMIT         = 3'd4;
    localparam logic [2:0] TS_MAX_SEEN        = 3'd4;
    localparam logic [2:0] WORD_BYTES         = 3'd4;
    localparam logic [7:0] NUM_CHANNELS_RESET = 8'd32;

    typedef struct packed {
        logic        emit;
        logic [4:0]  channel;
        logic [2:0]  byte_count;
        logic [31:0] payload;
    } itmd_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/itmd_parser.sv
// ---------------------------------------------------------------------------
// ITM packet parser
// Holds the packet state and decodes one registered byte per step.
// ---------------------------------------------------------------------------
`default_nettype none
`include "itm_trace_packet_decoder_defines.svh"

module itmd_parser
    import itmd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   data,
    input  wire logic [7:0]   num_channels,
    output itmd_result_t      result
);

    mode_t       mode_reg, mode_next;
    logic [2:0]  seen_reg, seen_next;
    logic [2:0]  expected_reg, expected_next;
    logic [4:0]  port_reg, port_next;
    logic [31:0] store_reg, store_next;
    logic [2:0]  seen_inc;
    logic [31:0] merged;

    assign seen_inc = seen_reg + 3'd1;
    // Byte lands at lane seen_reg; only lanes 0 to 3 exist.
    assign merged = (seen_reg < WORD_BYTES)
                  ? (store_reg | ({24'd0, data} << {seen_reg[1:0], 3'b000}))
                  : store_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        seen_next     = seen_reg;
        expected_next = expected_reg;
        port_next     = port_reg;
        store_next    = store_reg;
        result        = '0;
        result.channel    = port_reg;
        result.byte_count = expected_reg;
        result.payload    = merged;
        if (step)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (data == OVERFLOW_HDR)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (data == 8'd0)
                    begin
                        expected_next = SYNC_LIMIT;
                        seen_next     = 3'd0;
                        mode_next     = MODE_SYNC;
                    end
                    else if ((data & HDR_TYPE_MASK) == 8'd0)
                    begin
                        seen_next = 3'd1;
                        if ((data & CONT_BIT) != 8'd0)
                            mode_next = MODE_TS;
                    end
                    else if ((data & HDR_TYPE_MASK) == HDR_RESERVED)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if ((data & HDR_HW_BIT) == 8'd0)
                    begin
                        expected_next = (data[1:0] == SIZE_WORD) ? WORD_BYTES
                                                                 : {1'b0, data[1:0]};
                        port_next     = data[7:3];
                        seen_next     = 3'd0;
                        store_next    = '0;
                        mode_next     = MODE_SWIT;
                    end
                end
                MODE_SWIT:
                begin
                    store_next = merged;
                    seen_next  = seen_inc;
                    if (seen_inc >= expected_reg)
                    begin
                        mode_next   = MODE_IDLE;
                        result.emit = (expected_reg != 3'd0) &&
                                      ({3'd0, port_reg} < num_channels);
                    end
                end
                MODE_TS:
                begin
                    seen_next = seen_inc;
                    if ((data & CONT_BIT) == 8'd0 || seen_inc > TS_MAX_SEEN)
                        mode_next = MODE_IDLE;
                end
                MODE_SYNC:
                begin
                    if (data == 8'd0 && seen_reg < expected_reg)
                        seen_next = seen_inc;
                    else
                        mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            seen_reg     <= 3'd0;
            expected_reg <= 3'd0;
            port_reg     <= 5'd0;
            store_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            seen_reg     <= seen_next;
            expected_reg <= expected_next;
            port_reg     <= port_next;
            store_reg    <= store_next;
        end
    end

    // A software packet never holds more bytes than a word.
    `ITMD_ASSERT(a_swit_seen, clk, rst_n, (mode_reg != MODE_SWIT) || (seen_reg <= 3'd3))
    // A timestamp run counts from one and gives up after the fifth byte.
    `ITMD_ASSERT(a_ts_seen, clk, rst_n, (mode_reg != MODE_TS) || (seen_reg != 3'd0 && seen_reg <= TS_MAX_SEEN))
    // Emitted lengths are only one, two or four bytes.
    `ITMD_ASSERT(a_emit_len, clk, rst_n, !result.emit || result.byte_count == 3'd1 || result.byte_count == 3'd2 || result.byte_count == 3'd4)

endmodule

`default_nettype wire

FILE: hw/rtl/itm_trace_packet_decoder.sv
// ---------------------------------------------------------------------------
// ITM trace packet decoder
// Decodes an instrumentation trace byte stream into software packets.
// ---------------------------------------------------------------------------
//
//  Channel        Signals                              Direction  Request
//  rx             rx_valid, rx_stall, rx_byte          in         one trace byte
//  res            res_valid, res_stall, channel,       out        one software
//                 byte_count, payload                             packet
//  config         num_channels_we, num_channels        in         channel limit
//
// A byte is taken into the input register, decoded against the parser state
// once the result register is free, and any finished packet is placed in the
// result register. One byte is accepted per cycle while rx_stall is low; a
// packet passes through the input register and then the result register
// before it can be taken. rx_stall rises whenever a byte is held in the input
// register while the result register is full and its consumer is stalling,
// whether or not that byte would finish a packet. Reset empties both
// registers, returns the parser to idle and sets the channel limit to 32.
`default_nettype none
`include "itm_trace_packet_decoder_defines.svh"

module itm_trace_packet_decoder
    import itmd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        num_channels_we,
    input  wire logic [7:0]  num_channels,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [4:0]       channel,
    output logic [2:0]       byte_count,
    output logic [31:0]      payload
);

    logic         in_vld_reg, in_vld_next;
    logic [7:0]   in_byte_reg;
    logic         out_vld_reg, out_vld_next;
    logic [4:0]   channel_reg;
    logic [2:0]   byte_count_reg;
    logic [31:0]  payload_reg;
    logic [7:0]   limit_reg;
    logic         out_free;
    logic         advance;
    logic         rx_accept;
    itmd_result_t result;

    // The result register is free when empty or being emptied this cycle.
    assign out_free  = !out_vld_reg || !res_stall;
    // The held byte is decoded only when its result has somewhere to go.
    assign advance   = in_vld_reg && out_free;
    assign rx_stall  = in_vld_reg && !out_free;
    assign rx_accept = rx_valid && !rx_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (rx_accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = result.emit;
        else if (out_vld_reg && !res_stall)
            out_vld_next = 1'b0;
    end

    itmd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data         (in_byte_reg),
        .num_channels (limit_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            limit_reg   <= NUM_CHANNELS_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (num_channels_we)
                limit_reg <= num_channels;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (rx_accept)
            in_byte_reg <= rx_byte;
        if (advance && result.emit)
        begin
            channel_reg    <= result.channel;
            byte_count_reg <= result.byte_count;
            payload_reg    <= result.payload;
        end
    end

    assign res_valid  = out_vld_reg;
    assign channel    = channel_reg;
    assign byte_count = byte_count_reg;
    assign payload    = payload_reg;

    // An accepted byte is always held for decoding in the next cycle.
    `ITMD_ASSERT_NEXT(a_rx_held, clk, rst_n, rx_accept, in_vld_reg)
    // A byte that cannot be decoded is kept, not lost.
    `ITMD_ASSERT_NEXT(a_in_kept, clk, rst_n, in_vld_reg && !advance, in_vld_reg)
    // A decoded packet always reaches the result register.
    `ITMD_ASSERT_NEXT(a_emit_out, clk, rst_n, advance && result.emit, res_valid)

endmodule

`default_nettype wire
